// File: rtl/assert_macros.svh
// Assertion macros shared by the blit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while in reset.
`define ZF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("blit check failed: same-cycle implication");
// Next-cycle implication, disabled while in reset.
`define ZF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("blit check failed: next-cycle implication");
`else
`define ZF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ZF_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/zfcpb_pkg.sv
// Types, constants and lane helpers for the zoom/flip/clip pixel blit.
`default_nettype none
package zfcpb_pkg;

  localparam int COORD_BITS = 12;
  localparam int CFG_COORD_W = 12;
  localparam int MAX_ZOOM   = 8;
  localparam int ZOOM_W     = 4;
  localparam int POS_W      = COORD_BITS + 4;
  localparam int STRIDE_W   = 15;
  localparam int MAP_W      = 16;
  localparam int ADDR_W     = 26;
  localparam int WORD_W     = 32;
  localparam int CNT_W      = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LANES      = 4;

  localparam logic [ZOOM_W-1:0] ZOOM_RST     = ZOOM_W'(1);
  localparam logic [MAP_W-1:0]  LANE_MAP_RST = 16'h3210;
  localparam logic [7:0]        ALPHA_BYTE   = 8'hFF;

  typedef enum logic [2:0] {
    CFG_ZOOM           = 3'd0,
    CFG_DEST_START_ROW = 3'd1,
    CFG_DEST_START_COL = 3'd2,
    CFG_IMAGE_ROWS     = 3'd3,
    CFG_FRAME_ROWS     = 3'd4,
    CFG_FRAME_COLS     = 3'd5,
    CFG_LINE_STRIDE    = 3'd6,
    CFG_LANE_MAP       = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [ZOOM_W-1:0]      zoom;
    logic [CFG_COORD_W-1:0] dest_start_row;
    logic [CFG_COORD_W-1:0] dest_start_col;
    logic [CFG_COORD_W-1:0] image_rows;
    logic [CFG_COORD_W-1:0] frame_rows;
    logic [CFG_COORD_W-1:0] frame_cols;
    logic [STRIDE_W-1:0]    line_stride;
    logic [MAP_W-1:0]       lane_map;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] src_row;
    logic [COORD_BITS-1:0] src_col;
    logic [7:0]            src_red;
    logic [7:0]            src_green;
    logic [7:0]            src_blue;
  } in_beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [WORD_W-1:0] pixel_word;
    logic [CNT_W-1:0]  byte_count;
    logic              last;
  } out_beat_t;

  // One classified source pixel: first kept address and the kept block size.
  typedef struct packed {
    logic [ADDR_W-1:0] base_addr;
    logic [WORD_W-1:0] pixel_word;
    logic [CNT_W-1:0]  byte_count;
    logic [ZOOM_W-1:0] nrows;
    logic [ZOOM_W-1:0] ncols;
  } job_t;

  function automatic logic [CNT_W-1:0] count_lanes(input logic [MAP_W-1:0] map);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < LANES; i++) begin
      if (map[4*i +: 4] < 4'd4) n = n + CNT_W'(1);
    end
    return n;
  endfunction

  function automatic logic [WORD_W-1:0] place_byte(input logic [WORD_W-1:0] word,
                                                   input logic [3:0] lane,
                                                   input logic [7:0] data);
    logic [WORD_W-1:0] w;
    w = word;
    if (lane < 4'd4) w[{lane[1:0], 3'b000} +: 8] = data;
    return w;
  endfunction

  // Later channels win a shared lane; lanes at or above the count read zero.
  function automatic logic [WORD_W-1:0] build_word(input logic [MAP_W-1:0] map,
                                                   input logic [7:0] red,
                                                   input logic [7:0] green,
                                                   input logic [7:0] blue);
    logic [WORD_W-1:0] w;
    logic [CNT_W-1:0]  n;
    w = '0;
    n = count_lanes(map);
    w = place_byte(w, map[15:12], ALPHA_BYTE);
    w = place_byte(w, map[11:8], red);
    w = place_byte(w, map[7:4], green);
    w = place_byte(w, map[3:0], blue);
    for (int i = 0; i < LANES; i++) begin
      if (CNT_W'(i) >= n) w[8*i +: 8] = 8'h00;
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/zfcpb_queue.sv
// Small register queue of classified jobs between front and back.
`default_nettype none
`include "assert_macros.svh"
module zfcpb_queue
  import zfcpb_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output job_t job_o,
  output logic valid_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  job_t              mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_QW-1:0] count_r;

  assign full_o  = (count_r == CNT_QW'(DEPTH));
  assign valid_o = (count_r != '0);
  assign job_o   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= job_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push_i && !pop_i) count_r <= count_r + CNT_QW'(1);
      else if (pop_i && !push_i) count_r <= count_r - CNT_QW'(1);
    end
  end

  `ZF_ASSERT_IMP(a_q_no_overflow, clk, rst_n, push_i && !pop_i, count_r < CNT_QW'(DEPTH))
  `ZF_ASSERT_IMP(a_q_no_underflow, clk, rst_n, pop_i, count_r != '0)

endmodule
`default_nettype wire

// File: rtl/zfcpb_front.sv
// Front end: take a source pixel, clip its zoom block, queue the kept part.
`default_nettype none
`include "assert_macros.svh"
module zfcpb_front
  import zfcpb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_beat,
  input  cfg_t     cfg_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output job_t     q_job_o
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_PROD = 4'b0010,
    F_CLIP = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t state_r, state_nxt;

  in_beat_t          src_r;
  logic [ZOOM_W-1:0] z_r;
  logic              ok_r;
  logic [POS_W-1:0]  zir_r, zsrow_r, zscol_r;
  logic [WORD_W-1:0] word_r;
  logic [CNT_W-1:0]  nbytes_r;
  logic [POS_W-1:0]  r_first_r;
  logic [ZOOM_W-1:0] nrows_r, ncols_r;
  logic              keep_r;
  logic [ADDR_W-1:0] col_off_r;

  logic [ZOOM_W-1:0] z_clamp;
  logic [POS_W-1:0]  top, r0, excess, dcol0, rem, r_first;
  logic              over_row, row_drop, col_drop;
  logic [ZOOM_W-1:0] nrows, ncols;

  assign z_clamp = (cfg_i.zoom > ZOOM_W'(MAX_ZOOM)) ? ZOOM_W'(MAX_ZOOM) : cfg_i.zoom;

  // Flipped rows: block row dy lands on r0 - dy, so clipping drops leading rows.
  always_comb begin
    top      = POS_W'(cfg_i.dest_start_row) + zir_r;
    r0       = top - zsrow_r - POS_W'(1);
    over_row = (r0 >= POS_W'(cfg_i.frame_rows));
    excess   = r0 - POS_W'(cfg_i.frame_rows) + POS_W'(1);
    row_drop = over_row && (excess >= POS_W'(z_r));
    nrows    = over_row ? (z_r - excess[ZOOM_W-1:0]) : z_r;
    r_first  = over_row ? (POS_W'(cfg_i.frame_rows) - POS_W'(1)) : r0;
    dcol0    = POS_W'(cfg_i.dest_start_col) + zscol_r;
    col_drop = (dcol0 >= POS_W'(cfg_i.frame_cols));
    rem      = POS_W'(cfg_i.frame_cols) - dcol0;
    ncols    = (rem > POS_W'(z_r)) ? z_r : rem[ZOOM_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (in_valid) state_nxt = F_PROD;
      F_PROD: state_nxt = F_CLIP;
      F_CLIP: state_nxt = F_PUSH;
      F_PUSH: if (!keep_r || !q_full_i) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= F_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) src_r <= in_beat;
    if (state_r == F_PROD) begin
      z_r      <= z_clamp;
      ok_r     <= (z_clamp != '0) && (cfg_i.image_rows != '0) &&
                  (src_r.src_row < cfg_i.image_rows);
      zir_r    <= POS_W'(z_clamp) * POS_W'(cfg_i.image_rows);
      zsrow_r  <= POS_W'(z_clamp) * POS_W'(src_r.src_row);
      zscol_r  <= POS_W'(z_clamp) * POS_W'(src_r.src_col);
      word_r   <= build_word(cfg_i.lane_map, src_r.src_red, src_r.src_green,
                             src_r.src_blue);
      nbytes_r <= count_lanes(cfg_i.lane_map);
    end
    if (state_r == F_CLIP) begin
      r_first_r <= r_first;
      nrows_r   <= nrows;
      ncols_r   <= ncols;
      keep_r    <= ok_r && !row_drop && !col_drop;
      col_off_r <= ADDR_W'(nbytes_r) * ADDR_W'(dcol0);
    end
  end

  assign in_stall = (state_r != F_IDLE);
  assign q_push_o = (state_r == F_PUSH) && keep_r && !q_full_i;

  always_comb begin
    q_job_o.base_addr  = ADDR_W'(r_first_r) * ADDR_W'(cfg_i.line_stride) + col_off_r;
    q_job_o.pixel_word = word_r;
    q_job_o.byte_count = nbytes_r;
    q_job_o.nrows      = nrows_r;
    q_job_o.ncols      = ncols_r;
  end

  `ZF_ASSERT_IMP(a_push_nonempty, clk, rst_n, q_push_o,
                 (q_job_o.nrows != '0) && (q_job_o.ncols != '0))

endmodule
`default_nettype wire

// File: rtl/zfcpb_back.sv
// Back end: walk the kept block of a job and emit one pixel beat per cycle while out_stall is low.
`default_nettype none
`include "assert_macros.svh"
module zfcpb_back
  import zfcpb_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid_i,
  input  job_t                job_i,
  output logic                job_pop_o,
  input  logic [STRIDE_W-1:0] line_stride_i,
  output logic                out_valid,
  input  logic                out_stall,
  output out_beat_t           out_beat
);

  logic              active_r;
  logic [ZOOM_W-1:0] rows_left_r, col_r, ncols_r;
  logic [CNT_W-1:0]  nbytes_r;
  logic [WORD_W-1:0] word_r;
  logic [ADDR_W-1:0] row_base_r, addr_r;
  logic              out_valid_r;
  out_beat_t         out_beat_r;

  logic              emit, row_end, last_pix, fin, load;
  logic [ADDR_W-1:0] next_row_base;

  assign emit          = active_r && (!out_valid_r || !out_stall);
  assign row_end       = (col_r == ncols_r - ZOOM_W'(1));
  assign last_pix      = row_end && (rows_left_r == ZOOM_W'(1));
  assign fin           = emit && last_pix;
  assign load          = job_valid_i && (!active_r || fin);
  assign job_pop_o     = load;
  // Next block row sits one line up in the destination.
  assign next_row_base = row_base_r - ADDR_W'(line_stride_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      if (load) active_r <= 1'b1;
      else if (fin) active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_beat_r.byte_address <= addr_r;
      out_beat_r.pixel_word   <= word_r;
      out_beat_r.byte_count   <= nbytes_r;
      out_beat_r.last         <= last_pix;
    end
    if (load) begin
      rows_left_r <= job_i.nrows;
      col_r       <= '0;
      ncols_r     <= job_i.ncols;
      nbytes_r    <= job_i.byte_count;
      word_r      <= job_i.pixel_word;
      row_base_r  <= job_i.base_addr;
      addr_r      <= job_i.base_addr;
    end else if (emit) begin
      if (row_end) begin
        col_r       <= '0;
        rows_left_r <= rows_left_r - ZOOM_W'(1);
        row_base_r  <= next_row_base;
        addr_r      <= next_row_base;
      end else begin
        col_r  <= col_r + ZOOM_W'(1);
        addr_r <= addr_r + ADDR_W'(nbytes_r);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_beat  = out_beat_r;

  `ZF_ASSERT_IMP(a_active_counts, clk, rst_n, active_r,
                 (rows_left_r != '0) && (col_r < ncols_r))
  `ZF_ASSERT_NXT(a_last_ends_job, clk, rst_n, fin && !job_valid_i, !active_r)

endmodule
`default_nettype wire

// File: rtl/zoom_flip_clip_pixel_blit_top.sv
// Top level of the zoom/flip/clip pixel blit: configuration registers and wiring.
`default_nettype none
// Each accepted source pixel is replicated into a zoom-by-zoom block (zoom
// clamps at 8), flipped vertically against image_rows and clipped to
// frame_rows by frame_cols; every kept destination pixel leaves as one beat
// with its byte address, packed word and byte count, and last marks the
// final beat of a source pixel. A source pixel passes four front-end steps
// (capture, products, clipping, base address), after which the back end
// writes one beat per cycle, while out_stall is low, from a QUEUE_DEPTH-entry
// job queue; the front end can take the next source pixel while earlier
// jobs are still being written. A pixel with no kept beats produces nothing.
// Write configuration only while idle.
module zoom_flip_clip_pixel_blit_top
  import zfcpb_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_beat,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_beat,
  input  logic                  cfg_we,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r;
  logic q_push, q_full, q_pop, q_valid;
  job_t q_job_in, q_job_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{zoom: ZOOM_RST, lane_map: LANE_MAP_RST, default: '0};
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ZOOM:           cfg_r.zoom           <= cfg_data[ZOOM_W-1:0];
        CFG_DEST_START_ROW: cfg_r.dest_start_row <= cfg_data[CFG_COORD_W-1:0];
        CFG_DEST_START_COL: cfg_r.dest_start_col <= cfg_data[CFG_COORD_W-1:0];
        CFG_IMAGE_ROWS:     cfg_r.image_rows     <= cfg_data[CFG_COORD_W-1:0];
        CFG_FRAME_ROWS:     cfg_r.frame_rows     <= cfg_data[CFG_COORD_W-1:0];
        CFG_FRAME_COLS:     cfg_r.frame_cols     <= cfg_data[CFG_COORD_W-1:0];
        CFG_LINE_STRIDE:    cfg_r.line_stride    <= cfg_data[STRIDE_W-1:0];
        CFG_LANE_MAP:       cfg_r.lane_map       <= cfg_data[MAP_W-1:0];
        default:            cfg_r                <= cfg_r;
      endcase
    end
  end

  zfcpb_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .cfg_i    (cfg_r),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (q_job_in)
  );

  zfcpb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .job_o   (q_job_out),
    .valid_o (q_valid)
  );

  zfcpb_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .job_valid_i   (q_valid),
    .job_i         (q_job_out),
    .job_pop_o     (q_pop),
    .line_stride_i (cfg_r.line_stride),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_beat      (out_beat)
  );

endmodule
`default_nettype wire
